>>> rtl/core/fvpg_pkg.sv
// shared types, codes and helpers for the frame validity poison gate
// used by every module under rtl/core; depends on nothing
package fvpg_pkg;

   // width of the saturating drop and entry counters
   localparam int COUNT_WIDTH = 32;
   localparam int NUM_BITS    = 6;
   localparam int OUT_CNT_W   = 32;
   localparam int TIME_W      = 64;

   localparam int REQ_TDATA_W = 80;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 328;

   // commands
   localparam logic [1:0] CMD_JUDGE = 2'd0;
   localparam logic [1:0] CMD_FORCE = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   // validity bit positions
   localparam int BIT_REFS     = 0;
   localparam int BIT_PARAMS   = 1;
   localparam int BIT_RECOVERY = 2;
   localparam int BIT_COLOR    = 3;
   localparam int BIT_REORDER  = 4;
   localparam int BIT_FENCE    = 5;

   localparam logic [NUM_BITS-1:0] MASK_ALL = '1;
   localparam logic [NUM_BITS-1:0] MASK_REFS_RECOVERY =
      NUM_BITS'((1 << BIT_REFS) | (1 << BIT_RECOVERY));

   // poison causes
   localparam logic [2:0] CAUSE_NONE    = 3'd0;
   localparam logic [2:0] CAUSE_DECODE  = 3'd1;
   localparam logic [2:0] CAUSE_REFS    = 3'd2;
   localparam logic [2:0] CAUSE_PARAMS  = 3'd3;
   localparam logic [2:0] CAUSE_REORDER = 3'd4;
   localparam logic [2:0] CAUSE_FENCE   = 3'd5;
   localparam logic [2:0] CAUSE_COLOR   = 3'd6;

   typedef logic [COUNT_WIDTH-1:0] count_type;

   typedef struct packed {
      logic [1:0]          command;
      logic                dec_fail;
      logic [NUM_BITS-1:0] valid_bits;
      logic                key_frame;
      logic [TIME_W-1:0]   frame_time;
      logic [2:0]          forced_source;
   } req_item_type;

   typedef struct packed {
      logic                 admitted;
      logic                 poison_now;
      logic [2:0]           poison_cause;
      logic [OUT_CNT_W-1:0] refs_drop_total;
      logic [OUT_CNT_W-1:0] params_drop_total;
      logic [OUT_CNT_W-1:0] recovery_drop_total;
      logic [OUT_CNT_W-1:0] color_drop_total;
      logic [OUT_CNT_W-1:0] reorder_drop_total;
      logic [OUT_CNT_W-1:0] fence_drop_total;
      logic [TIME_W-1:0]    last_dropped_time;
      logic [OUT_CNT_W-1:0] poison_entries;
      logic [OUT_CNT_W-1:0] poisoned_drops;
   } rsp_item_type;

   function automatic count_type sat_inc(input count_type v);
      return (v == '1) ? v : count_type'(v + 1'b1);
   endfunction

   // low bits of a counter, zero extended when the counter is narrow
   function automatic logic [OUT_CNT_W-1:0] to_out(input count_type v);
      logic [COUNT_WIDTH+OUT_CNT_W-1:0] ext;
      ext = {{OUT_CNT_W{1'b0}}, v};
      return ext[OUT_CNT_W-1:0];
   endfunction

   // cause picked by priority: refs, recovery, params, reorder, fence, color
   function automatic logic [2:0] cause_of(input logic [NUM_BITS-1:0] missing);
      logic [2:0] c;
      if (missing[BIT_REFS] || missing[BIT_RECOVERY]) c = CAUSE_REFS;
      else if (missing[BIT_PARAMS])                   c = CAUSE_PARAMS;
      else if (missing[BIT_REORDER])                  c = CAUSE_REORDER;
      else if (missing[BIT_FENCE])                    c = CAUSE_FENCE;
      else if (missing[BIT_COLOR])                    c = CAUSE_COLOR;
      else                                            c = CAUSE_NONE;
      return c;
   endfunction

endpackage

>>> rtl/core/fvpg_in_reg.sv
// input register of the poison gate: takes one item and unpacks the stream word
// depends on fvpg_pkg
module fvpg_in_reg (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [fvpg_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic [fvpg_pkg::REQ_TUSER_W-1:0] req_tuser,
   input  logic                            take,
   output logic                            item_valid,
   output fvpg_pkg::req_item_type          item
);

   logic                   valid_ff, valid_in;
   fvpg_pkg::req_item_type item_ff, item_in;

   assign req_tready = !valid_ff || take;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (take) valid_in = 1'b0;
      if (req_tvalid && req_tready) valid_in = 1'b1;
      item_in.command       = req_tuser[1:0];
      item_in.dec_fail      = req_tdata[0];
      item_in.valid_bits    = req_tdata[6:1];
      item_in.key_frame     = req_tdata[7];
      item_in.frame_time    = req_tdata[71:8];
      item_in.forced_source = req_tdata[74:72];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= item_in;
      end
   end

endmodule

>>> rtl/core/fvpg_core.sv
// gate state and decision logic: poison flag, cause and drop counters
// depends on fvpg_pkg
module fvpg_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  fvpg_pkg::req_item_type item,
   output fvpg_pkg::rsp_item_type result
);

   logic                           poisoned_ff, poisoned_in;
   logic [2:0]                     cause_ff, cause_in;
   fvpg_pkg::count_type            bit_cnt_ff [fvpg_pkg::NUM_BITS];
   fvpg_pkg::count_type            bit_cnt_in [fvpg_pkg::NUM_BITS];
   logic [fvpg_pkg::TIME_W-1:0]    last_time_ff, last_time_in;
   fvpg_pkg::count_type            entry_ff, entry_in;
   fvpg_pkg::count_type            drop_ff, drop_in;

   logic                           admit;
   logic                           do_enter;
   logic [2:0]                     enter_cause;
   logic                           do_drop;
   logic [fvpg_pkg::NUM_BITS-1:0]  drop_mask;
   logic                           do_unpoison;
   logic                           do_clear;
   logic [fvpg_pkg::NUM_BITS-1:0]  missing;

   assign missing = fvpg_pkg::MASK_ALL & ~item.valid_bits;

   always_comb begin
      admit       = 1'b0;
      do_enter    = 1'b0;
      enter_cause = fvpg_pkg::CAUSE_NONE;
      do_drop     = 1'b0;
      drop_mask   = '0;
      do_unpoison = 1'b0;
      do_clear    = 1'b0;
      unique case (item.command)
         fvpg_pkg::CMD_JUDGE: begin
            if (item.dec_fail) begin
               do_enter    = !poisoned_ff;
               enter_cause = fvpg_pkg::CAUSE_DECODE;
               do_drop     = 1'b1;
               drop_mask   = fvpg_pkg::MASK_REFS_RECOVERY;
            end else if (missing != '0) begin
               do_enter    = !poisoned_ff;
               enter_cause = fvpg_pkg::cause_of(missing);
               do_drop     = 1'b1;
               drop_mask   = missing;
            end else if (!poisoned_ff) begin
               admit = 1'b1;
            end else if (item.key_frame) begin
               do_unpoison = 1'b1;
               admit       = 1'b1;
            end else begin
               // clean frame while poisoned but not a keyframe
               do_drop   = 1'b1;
               drop_mask = fvpg_pkg::MASK_REFS_RECOVERY;
            end
         end
         fvpg_pkg::CMD_FORCE: begin
            // forcing the cause already held is a no-op; code 7 is ignored
            if (item.forced_source <= fvpg_pkg::CAUSE_COLOR &&
                !(poisoned_ff && cause_ff == item.forced_source)) begin
               do_enter    = 1'b1;
               enter_cause = item.forced_source;
            end
         end
         fvpg_pkg::CMD_CLEAR: begin
            do_clear = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      poisoned_in  = poisoned_ff;
      cause_in     = cause_ff;
      last_time_in = last_time_ff;
      entry_in     = entry_ff;
      drop_in      = drop_ff;
      for (int i = 0; i < fvpg_pkg::NUM_BITS; i++) begin
         bit_cnt_in[i] = bit_cnt_ff[i];
      end
      if (do_clear) begin
         poisoned_in  = 1'b0;
         cause_in     = fvpg_pkg::CAUSE_NONE;
         last_time_in = '0;
         entry_in     = '0;
         drop_in      = '0;
         for (int i = 0; i < fvpg_pkg::NUM_BITS; i++) begin
            bit_cnt_in[i] = '0;
         end
      end else begin
         if (do_enter) begin
            poisoned_in = 1'b1;
            cause_in    = enter_cause;
            entry_in    = fvpg_pkg::sat_inc(entry_ff);
         end
         if (do_unpoison) begin
            poisoned_in = 1'b0;
            cause_in    = fvpg_pkg::CAUSE_NONE;
         end
         if (do_drop) begin
            last_time_in = item.frame_time;
            drop_in      = fvpg_pkg::sat_inc(drop_ff);
            for (int i = 0; i < fvpg_pkg::NUM_BITS; i++) begin
               if (drop_mask[i]) bit_cnt_in[i] = fvpg_pkg::sat_inc(bit_cnt_ff[i]);
            end
         end
      end
   end

   always_comb begin
      result.admitted            = admit;
      result.poison_now          = poisoned_in;
      result.poison_cause        = cause_in;
      result.refs_drop_total     = fvpg_pkg::to_out(bit_cnt_in[fvpg_pkg::BIT_REFS]);
      result.params_drop_total   = fvpg_pkg::to_out(bit_cnt_in[fvpg_pkg::BIT_PARAMS]);
      result.recovery_drop_total = fvpg_pkg::to_out(bit_cnt_in[fvpg_pkg::BIT_RECOVERY]);
      result.color_drop_total    = fvpg_pkg::to_out(bit_cnt_in[fvpg_pkg::BIT_COLOR]);
      result.reorder_drop_total  = fvpg_pkg::to_out(bit_cnt_in[fvpg_pkg::BIT_REORDER]);
      result.fence_drop_total    = fvpg_pkg::to_out(bit_cnt_in[fvpg_pkg::BIT_FENCE]);
      result.last_dropped_time   = last_time_in;
      result.poison_entries      = fvpg_pkg::to_out(entry_in);
      result.poisoned_drops      = fvpg_pkg::to_out(drop_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poisoned_ff  <= 1'b0;
         cause_ff     <= fvpg_pkg::CAUSE_NONE;
         last_time_ff <= '0;
         entry_ff     <= '0;
         drop_ff      <= '0;
         for (int i = 0; i < fvpg_pkg::NUM_BITS; i++) begin
            bit_cnt_ff[i] <= '0;
         end
      end else if (fire) begin
         poisoned_ff  <= poisoned_in;
         cause_ff     <= cause_in;
         last_time_ff <= last_time_in;
         entry_ff     <= entry_in;
         drop_ff      <= drop_in;
         for (int i = 0; i < fvpg_pkg::NUM_BITS; i++) begin
            bit_cnt_ff[i] <= bit_cnt_in[i];
         end
      end
   end

endmodule

>>> rtl/core/frame_validity_poison_gate_unit.sv
// Frame validity poison gate. Each item is a command: judge a frame, force the
// gate poisoned with a given cause, or clear all state. Every item gives one
// result with the admit decision, the poison flag and cause, and all counters
// as they stand after that item. One item is taken per cycle while results are
// not stalled; an item waits in the input register, is judged and updates the
// gate state when it moves on, and its result is then held in the result
// register, written only when that register is empty or being drained. A stalled
// result holds the input register and then input.
// depends on fvpg_pkg, fvpg_in_reg and fvpg_core
module frame_validity_poison_gate_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // dec_fail, valid_bits[5:0], key_frame, frame_time[63:0],
   // forced_source[2:0], zero pad
   input  logic [fvpg_pkg::REQ_TDATA_W-1:0] req_tdata,
   // command[1:0]
   input  logic [fvpg_pkg::REQ_TUSER_W-1:0] req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // admitted, poison_now, poison_cause[2:0], refs_drop_total,
   // params_drop_total, recovery_drop_total, color_drop_total,
   // reorder_drop_total, fence_drop_total, last_dropped_time[63:0],
   // poison_entries, poisoned_drops (counters 32 bits each), zero pad
   output logic [fvpg_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   logic                   item_valid;
   fvpg_pkg::req_item_type item;
   fvpg_pkg::rsp_item_type result;
   logic                   fire;
   logic                   rsp_valid_ff, rsp_valid_in;
   fvpg_pkg::rsp_item_type rsp_ff;

   // an item moves on when the result register is empty or being drained
   assign fire = item_valid && (!rsp_valid_ff || rsp_tready);

   fvpg_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .take       (fire),
      .item_valid (item_valid),
      .item       (item)
   );

   fvpg_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item),
      .result (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) rsp_valid_in = 1'b0;
      if (fire) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      rsp_tdata          = '0;
      rsp_tdata[0]       = rsp_ff.admitted;
      rsp_tdata[1]       = rsp_ff.poison_now;
      rsp_tdata[4:2]     = rsp_ff.poison_cause;
      rsp_tdata[36:5]    = rsp_ff.refs_drop_total;
      rsp_tdata[68:37]   = rsp_ff.params_drop_total;
      rsp_tdata[100:69]  = rsp_ff.recovery_drop_total;
      rsp_tdata[132:101] = rsp_ff.color_drop_total;
      rsp_tdata[164:133] = rsp_ff.reorder_drop_total;
      rsp_tdata[196:165] = rsp_ff.fence_drop_total;
      rsp_tdata[260:197] = rsp_ff.last_dropped_time;
      rsp_tdata[292:261] = rsp_ff.poison_entries;
      rsp_tdata[324:293] = rsp_ff.poisoned_drops;
   end

endmodule
